// ===== rtl/core/tcof_pkg.sv =====
// shared types and codes for the two-class ordered fifo
// request and response words, internal command word, stored entry layout
// no dependencies
package tcof_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int ID_W        = 20;
    localparam int SEQ_W       = 6;
    localparam int REQ_W       = 3;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = 5;
    localparam int OP_W        = 3;

    // request codes on the input word
    localparam logic [REQ_W-1:0] REQ_ADD       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DRAIN_ALL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DRAIN_DOG = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DRAIN_CAT = 3'd3;
    localparam logic [REQ_W-1:0] REQ_STATUS    = 3'd4;

    localparam logic KIND_DOG = 1'b0;
    localparam logic KIND_CAT = 1'b1;

    // internal operations after classification
    localparam logic [OP_W-1:0] OP_ADD_DOG   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_CAT   = 3'd1;
    localparam logic [OP_W-1:0] OP_DRAIN_ALL = 3'd2;
    localparam logic [OP_W-1:0] OP_DRAIN_DOG = 3'd3;
    localparam logic [OP_W-1:0] OP_DRAIN_CAT = 3'd4;
    localparam logic [OP_W-1:0] OP_STATUS    = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             pet_kind;
        logic [ID_W-1:0]  pet_id;
    } req_t;

    typedef struct packed {
        logic            has_pet;
        logic            out_kind;
        logic [ID_W-1:0] out_id;
        logic            last;
        logic            all_empty;
        logic            dog_empty;
        logic            cat_empty;
        logic            overflow;
    } rsp_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] pet_id;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SEQ_W-1:0] stamp;
    } entry_t;

endpackage

// ===== rtl/core/tcof_front.sv =====
// front end: classifies request words into commands and queues them
// two-entry command queue decouples the request side from the back end
// depends on tcof_pkg
module tcof_front
    import tcof_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic cmd_valid,
    output cmd_t cmd,
    input  logic cmd_take
);

    localparam int QD = 2;

    cmd_t       q_mem [QD];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.pet_id = req.pet_id;
        unique case (req.req_type)
            REQ_ADD:       cmd_in.op = (req.pet_kind == KIND_CAT) ? OP_ADD_CAT : OP_ADD_DOG;
            REQ_DRAIN_ALL: cmd_in.op = OP_DRAIN_ALL;
            REQ_DRAIN_DOG: cmd_in.op = OP_DRAIN_DOG;
            REQ_DRAIN_CAT: cmd_in.op = OP_DRAIN_CAT;
            default:       cmd_in.op = OP_STATUS;
        endcase
    end

    assign req_stall = (cnt_reg == 2'(QD));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/core/tcof_back.sv =====
// back end: the two class fifos, arrival stamping, drain sequencer
// and the registered response word
// depends on tcof_pkg
module tcof_back
    import tcof_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    input  cmd_t cmd,
    output logic cmd_take,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    entry_t dog_mem [DEPTH];
    entry_t cat_mem [DEPTH];

    logic [AW-1:0]    dog_head_reg, dog_head_next, dog_tail_reg, dog_tail_next;
    logic [AW-1:0]    cat_head_reg, cat_head_next, cat_tail_reg, cat_tail_next;
    logic [FW-1:0]    dog_fill_reg, dog_fill_next, cat_fill_reg, cat_fill_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic             state_reg, state_next;
    logic             use_dog_reg, use_dog_next, use_cat_reg, use_cat_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic             can_go;
    logic             rsp_load;
    logic             dog_we, cat_we;
    entry_t           wr_entry;
    entry_t           dog_hd_reg, cat_hd_reg;
    logic             dog_ok, cat_ok, take_cat, more, fin;
    logic [SEQ_W-1:0] stamp_diff;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign stamp_diff = dog_hd_reg.stamp - cat_hd_reg.stamp;
    assign dog_ok     = use_dog_reg && (dog_fill_reg != '0);
    assign cat_ok     = use_cat_reg && (cat_fill_reg != '0);
    // older head first; a set top bit of the difference means the dog is older
    assign take_cat   = cat_ok && (!dog_ok || !stamp_diff[SEQ_W-1]);

    assign can_go    = !rsp_valid_reg || !rsp_stall;
    assign cmd_take  = can_go && (state_reg == ST_IDLE);
    assign wr_entry  = '{id: cmd.pet_id, stamp: seq_reg};

    always_comb
    begin
        dog_head_next = dog_head_reg;
        dog_tail_next = dog_tail_reg;
        cat_head_next = cat_head_reg;
        cat_tail_next = cat_tail_reg;
        dog_fill_next = dog_fill_reg;
        cat_fill_next = cat_fill_reg;
        seq_next      = seq_reg;
        state_next    = state_reg;
        use_dog_next  = use_dog_reg;
        use_cat_next  = use_cat_reg;
        cnt_next      = cnt_reg;
        dog_we        = 1'b0;
        cat_we        = 1'b0;
        rsp_load      = 1'b0;
        more          = 1'b0;
        fin           = 1'b0;
        rsp_next      = '0;
        rsp_next.last = 1'b1;

        if (can_go && state_reg == ST_DRAIN)
        begin
            rsp_load = 1'b1;
            if (dog_ok || cat_ok)
            begin
                rsp_next.has_pet  = 1'b1;
                rsp_next.out_kind = take_cat ? KIND_CAT : KIND_DOG;
                if (take_cat)
                begin
                    rsp_next.out_id = cat_hd_reg.id;
                    cat_head_next   = bump(cat_head_reg);
                    cat_fill_next   = cat_fill_reg - 1'b1;
                end
                else
                begin
                    rsp_next.out_id = dog_hd_reg.id;
                    dog_head_next   = bump(dog_head_reg);
                    dog_fill_next   = dog_fill_reg - 1'b1;
                end
                more = (use_dog_reg && dog_fill_next != '0) ||
                       (use_cat_reg && cat_fill_next != '0);
                fin  = !more || (cnt_reg == CNT_W'(MAX_RESULTS - 1));
                rsp_next.last = fin;
                cnt_next      = cnt_reg + 1'b1;
                if (fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            else
            begin
                // nothing to drain: single empty word
                state_next = ST_IDLE;
            end
        end
        else if (cmd_take && cmd_valid)
        begin
            unique case (cmd.op)
                OP_ADD_DOG:
                begin
                    rsp_load = 1'b1;
                    if (dog_fill_reg == FW'(DEPTH))
                    begin
                        rsp_next.overflow = 1'b1;
                    end
                    else
                    begin
                        dog_we        = 1'b1;
                        dog_tail_next = bump(dog_tail_reg);
                        dog_fill_next = dog_fill_reg + 1'b1;
                        seq_next      = seq_reg + 1'b1;
                    end
                end
                OP_ADD_CAT:
                begin
                    rsp_load = 1'b1;
                    if (cat_fill_reg == FW'(DEPTH))
                    begin
                        rsp_next.overflow = 1'b1;
                    end
                    else
                    begin
                        cat_we        = 1'b1;
                        cat_tail_next = bump(cat_tail_reg);
                        cat_fill_next = cat_fill_reg + 1'b1;
                        seq_next      = seq_reg + 1'b1;
                    end
                end
                OP_DRAIN_ALL, OP_DRAIN_DOG, OP_DRAIN_CAT:
                begin
                    state_next   = ST_DRAIN;
                    use_dog_next = (cmd.op != OP_DRAIN_CAT);
                    use_cat_next = (cmd.op != OP_DRAIN_DOG);
                    cnt_next     = '0;
                end
                default:
                begin
                    rsp_load = 1'b1;
                end
            endcase
        end

        rsp_next.dog_empty = (dog_fill_next == '0);
        rsp_next.cat_empty = (cat_fill_next == '0);
        rsp_next.all_empty = rsp_next.dog_empty && rsp_next.cat_empty;
        rsp_valid_next     = rsp_load || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dog_head_reg  <= '0;
            dog_tail_reg  <= '0;
            cat_head_reg  <= '0;
            cat_tail_reg  <= '0;
            dog_fill_reg  <= '0;
            cat_fill_reg  <= '0;
            seq_reg       <= '0;
            state_reg     <= ST_IDLE;
            use_dog_reg   <= 1'b0;
            use_cat_reg   <= 1'b0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            dog_head_reg  <= dog_head_next;
            dog_tail_reg  <= dog_tail_next;
            cat_head_reg  <= cat_head_next;
            cat_tail_reg  <= cat_tail_next;
            dog_fill_reg  <= dog_fill_next;
            cat_fill_reg  <= cat_fill_next;
            seq_reg       <= seq_next;
            state_reg     <= state_next;
            use_dog_reg   <= use_dog_next;
            use_cat_reg   <= use_cat_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
        if (dog_we)
        begin
            dog_mem[dog_tail_reg] <= wr_entry;
        end
        if (cat_we)
        begin
            cat_mem[cat_tail_reg] <= wr_entry;
        end
        // head word follows the head index; a write into an empty fifo lands on the head
        if (dog_we && (dog_tail_reg == dog_head_next))
        begin
            dog_hd_reg <= wr_entry;
        end
        else
        begin
            dog_hd_reg <= dog_mem[dog_head_next];
        end
        if (cat_we && (cat_tail_reg == cat_head_next))
        begin
            cat_hd_reg <= wr_entry;
        end
        else
        begin
            cat_hd_reg <= cat_mem[cat_head_next];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dog_fill_reg <= FW'(DEPTH)) && (cat_fill_reg <= FW'(DEPTH)))
        else $error("class fifo fill beyond depth");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> ($stable(dog_fill_reg) && $stable(cat_fill_reg)))
        else $error("fifo state moved while response word stalled");

    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> ((rsp_reg.dog_empty == (dog_fill_reg == '0)) &&
                           (rsp_reg.cat_empty == (cat_fill_reg == '0))))
        else $error("empty flags disagree with fill counts");

    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.has_pet && !rsp_reg.last) |-> (state_reg == ST_DRAIN))
        else $error("drain ended before last word");

endmodule

// ===== rtl/core/two_class_ordered_fifo.sv =====
// top level of the two-class ordered fifo (dog and cat queues)
// request channel: req_valid / req_stall / req; response channel: rsp_valid / rsp_stall / rsp
// a request is taken on a clock edge with valid high and stall low, likewise a response.
// requests pass a two-entry command queue (front) into the fifo engine (back).
// add and status: one response word each, held in the back end's response register;
// back to back they run at one request per cycle while the receiver does not stall.
// drain: a start step enters the drain state, then one dequeued word per cycle while the
// receiver does not stall, the final word marked last; an empty drain gives a single
// empty word.
// at most 32 words per drain request; the rest stay queued.
// rate is set by the back end, which does one action per cycle while the response word
// is not stalled, on the single head read port of each class fifo.
// every word carries the emptiness flags as they stand after it.
// reset empties both fifos, clears the arrival counter and drops queued requests.
// when the receiver stalls, the response word holds, the back end freezes and the
// front keeps taking requests until its two-entry queue is full.
// depends on tcof_pkg, tcof_front, tcof_back
module two_class_ordered_fifo
    import tcof_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    tcof_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tcof_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

// ===== tb/sv/tcof_checker.sv =====
`timescale 1ns / 100ps
// response checker for the two-class ordered fifo: keeps its own dog and cat queues,
// works out every response word each accepted request causes and compares them in order
// depends on tcof_pkg
module tcof_checker
    import tcof_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_stall,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    localparam int QDEPTH = DEPTH_DEF;
    localparam int PTR_W  = $clog2(QDEPTH);

    // index 0 holds the dogs, index 1 the cats
    entry_t           pen     [2][QDEPTH];
    logic [PTR_W-1:0] rd_ptr  [2];
    logic [PTR_W-1:0] wr_ptr  [2];
    logic [CNT_W-1:0] count   [2];
    logic [SEQ_W-1:0] next_stamp;

    rsp_t due_words[$];
    rsp_t want;

    function automatic rsp_t make_word(input logic has, input logic kind,
                                       input logic [ID_W-1:0] id, input logic fin,
                                       input logic ovf);
        rsp_t w;
        w.has_pet   = has;
        w.out_kind  = kind;
        w.out_id    = id;
        w.last      = fin;
        w.dog_empty = (count[KIND_DOG] == 0);
        w.cat_empty = (count[KIND_CAT] == 0);
        w.all_empty = w.dog_empty && w.cat_empty;
        w.overflow  = ovf;
        return w;
    endfunction

    task automatic predict_request(input req_t r);
        logic             k;
        logic             dog_ok;
        logic             cat_ok;
        logic [SEQ_W-1:0] gap;
        entry_t           popped;
        int               n;
        n = 0;
        if (r.req_type == REQ_ADD) begin
            k = r.pet_kind;
            if (count[k] == QDEPTH) begin
                // full class: item dropped, stamp not used up
                due_words.push_back(make_word(1'b0, KIND_DOG, '0, 1'b1, 1'b1));
            end
            else begin
                pen[k][wr_ptr[k]].id    = r.pet_id;
                pen[k][wr_ptr[k]].stamp = next_stamp;
                wr_ptr[k]  = wr_ptr[k] + 1'b1;
                count[k]   = count[k] + 1'b1;
                next_stamp = next_stamp + 1'b1;
                due_words.push_back(make_word(1'b0, KIND_DOG, '0, 1'b1, 1'b0));
            end
        end
        else if (r.req_type inside {REQ_DRAIN_ALL, REQ_DRAIN_DOG, REQ_DRAIN_CAT}) begin
            dog_ok = (r.req_type != REQ_DRAIN_CAT) && (count[KIND_DOG] != 0);
            cat_ok = (r.req_type != REQ_DRAIN_DOG) && (count[KIND_CAT] != 0);
            while (n < MAX_RESULTS && (dog_ok || cat_ok)) begin
                if (dog_ok && cat_ok) begin
                    // modular stamp compare, dog first when the difference is negative
                    gap = pen[KIND_DOG][rd_ptr[KIND_DOG]].stamp
                        - pen[KIND_CAT][rd_ptr[KIND_CAT]].stamp;
                    k = gap[SEQ_W-1] ? KIND_DOG : KIND_CAT;
                end
                else begin
                    k = cat_ok ? KIND_CAT : KIND_DOG;
                end
                popped    = pen[k][rd_ptr[k]];
                rd_ptr[k] = rd_ptr[k] + 1'b1;
                count[k]  = count[k] - 1'b1;
                dog_ok = (r.req_type != REQ_DRAIN_CAT) && (count[KIND_DOG] != 0);
                cat_ok = (r.req_type != REQ_DRAIN_DOG) && (count[KIND_CAT] != 0);
                due_words.push_back(make_word(1'b1, k, popped.id,
                    !(dog_ok || cat_ok) || (n == MAX_RESULTS - 1), 1'b0));
                n++;
            end
            if (n == 0)
                due_words.push_back(make_word(1'b0, KIND_DOG, '0, 1'b1, 1'b0));
        end
        else begin
            // status and the unused codes
            due_words.push_back(make_word(1'b0, KIND_DOG, '0, 1'b1, 1'b0));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr[KIND_DOG] = '0;
            rd_ptr[KIND_CAT] = '0;
            wr_ptr[KIND_DOG] = '0;
            wr_ptr[KIND_CAT] = '0;
            count[KIND_DOG]  = '0;
            count[KIND_CAT]  = '0;
            next_stamp       = '0;
            due_words.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_words.size() == 0)
                begin
                    $display("%0t: unexpected response word %p", $time, rsp);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = due_words.pop_front();
                    if (rsp.has_pet !== want.has_pet || rsp.out_kind !== want.out_kind ||
                        rsp.out_id !== want.out_id || rsp.last !== want.last ||
                        rsp.all_empty !== want.all_empty ||
                        rsp.dog_empty !== want.dog_empty ||
                        rsp.cat_empty !== want.cat_empty || rsp.overflow !== want.overflow)
                    begin
                        $display("%0t: response mismatch, expected %p", $time, want);
                        $display("%0t: response mismatch, actual   %p", $time, rsp);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (req_valid && !req_stall)
                predict_request(req);
            outstanding <= due_words.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// stimulus and verdict for the two-class ordered fifo
// depends on tcof_pkg, two_class_ordered_fifo and tcof_checker
module tb;
    import tcof_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    int fails;
    int outstanding;
    int cycles    = 0;
    int gap_pct   = 0;
    int stall_pct = 0;

    two_class_ordered_fifo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    tcof_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .mismatches  (fails),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("two_class_ordered_fifo test failed");
            $finish;
        end
    end

    task automatic post(input logic [REQ_W-1:0] code, input logic kind,
                        input logic [ID_W-1:0] id);
        req_t w;
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        w.req_type = code;
        w.pet_kind = kind;
        w.pet_id   = id;
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic wait_settled();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic random_item();
        int               pick;
        logic [REQ_W-1:0] code;
        pick = $urandom_range(99);
        if (pick < 55)
            code = REQ_ADD;
        else if (pick < 68)
            code = REQ_DRAIN_ALL;
        else if (pick < 77)
            code = REQ_DRAIN_DOG;
        else if (pick < 86)
            code = REQ_DRAIN_CAT;
        else if (pick < 94)
            code = REQ_STATUS;
        else
            code = REQ_W'($urandom_range(2**REQ_W - 1, REQ_STATUS + 1));
        post(code, 1'($urandom_range(1)), ID_W'($urandom));
    endtask

    // both classes to full and one past, in random interleave, then one long drain
    task automatic fill_both_then_drain();
        int   dogs;
        int   cats;
        logic k;
        dogs = 0;
        cats = 0;
        while (dogs <= DEPTH_DEF || cats <= DEPTH_DEF)
        begin
            k = 1'($urandom_range(1));
            if (dogs > DEPTH_DEF)
                k = KIND_CAT;
            else if (cats > DEPTH_DEF)
                k = KIND_DOG;
            post(REQ_ADD, k, ID_W'($urandom));
            if (k == KIND_CAT)
                cats++;
            else
                dogs++;
        end
        post(REQ_DRAIN_ALL, 1'($urandom_range(1)), ID_W'($urandom));
    endtask

    initial
    begin
        int i;
        gap_pct   = 29;
        stall_pct = 81;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty block: status, the three drains, then the unused codes
        post(REQ_STATUS, KIND_CAT, '1);
        post(REQ_DRAIN_ALL, KIND_DOG, '0);
        post(REQ_DRAIN_DOG, KIND_CAT, '0);
        post(REQ_DRAIN_CAT, KIND_DOG, '1);
        for (i = REQ_STATUS + 1; i < 2**REQ_W; i++)
            post(REQ_W'(i), 1'(i), ID_W'($urandom));

        // cats first so they are older, then dogs to full plus one dropped
        post(REQ_ADD, KIND_CAT, '0);
        post(REQ_ADD, KIND_CAT, '1);
        for (i = 0; i <= DEPTH_DEF; i++)
            post(REQ_ADD, KIND_DOG, (i == 0) ? '0 : (i == 1) ? '1 : ID_W'($urandom));
        post(REQ_DRAIN_ALL, KIND_CAT, '1);

        fill_both_then_drain();
        for (i = 0; i < 10; i++)
            random_item();

        // hold off until every expected word is back
        wait_settled();
        gap_pct   = 81;
        stall_pct = 29;
        for (i = 0; i < 25; i++)
            random_item();

        wait_settled();
        gap_pct   = 0;
        stall_pct = 0;
        for (i = 0; i < 25; i++)
            random_item();

        wait_settled();
        repeat (20) @(posedge clk);
        if (fails == 0 && outstanding == 0)
            $display("two_class_ordered_fifo test passed");
        else
            $display("two_class_ordered_fifo test failed");
        $finish;
    end

endmodule

// ===== two_class_ordered_fifo.f =====
rtl/core/tcof_pkg.sv
rtl/core/tcof_front.sv
rtl/core/tcof_back.sv
rtl/core/two_class_ordered_fifo.sv
tb/sv/tcof_checker.sv
tb/sv/tb.sv
